// File: src/mwee_pkg.sv
package mwee_pkg;

  // field widths fixed by the item format
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POLL_W      = 10;
  localparam int unsigned BITS_W      = 5;
  localparam int unsigned SEND_W      = 27;

  // defaults for the top level parameters
  localparam int unsigned WORD_COUNT_DEF   = 128;
  localparam int unsigned ADDRESS_BITS_DEF = 8;

  // sequence lengths
  localparam logic [BITS_W-1:0] ZERO_TICKS = 5'd5;
  localparam logic [BITS_W-1:0] POLL_BITS  = 5'd10;
  localparam logic [BITS_W-1:0] WORD_BITS  = 5'd16;

  // poll limit after reset
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 10'd100;

  // start bit plus opcode patterns
  localparam logic [2:0] PAT_READ  = 3'b110;
  localparam logic [2:0] PAT_WRITE = 3'b101;
  localparam logic [4:0] PAT_WEN   = 5'b10011;
  localparam logic [4:0] PAT_WDS   = 5'b10000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WEN   = 3'd3,
    OP_WDS   = 3'd4
  } mwee_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2,
    ST_BUSY    = 2'd3
  } mwee_status_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SEND     = 3'd1,
    MODE_RECV     = 3'd2,
    MODE_ZERO_MID = 3'd3,
    MODE_POLL     = 3'd4,
    MODE_ZERO_END = 3'd5
  } mwee_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] write_data;
    logic              serial_in;
  } mwee_req_t;

  typedef struct packed {
    logic                chip_select;
    logic                serial_clock;
    logic                serial_out;
    logic                busy_res;
    logic                done_res;
    logic [WORD_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } mwee_res_t;

endpackage

// File: src/microwire_eeprom_master.sv
// Microwire master for a 16-bit serial EEPROM, paced by half-bit tick requests.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per half bit of
// the serial clock; a request may start a read, write, write enable or write
// disable, or just advance the running command.
// Output channel (out_valid_o / out_stall_i / out_res_o): one result per request
// with the pin levels for that half bit, busy, a done pulse, read data and status.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): the poll limit, always
// ready; write it only while no command is in progress.
// A request passes through the request register and then the result register.
// Throughput: one request per cycle unless the receiver stalls; each request makes
// a single pass through the next-state logic between the two registers.
// When the receiver stalls, the result register holds and the request register
// fills; once both are full, in_stall_o is raised.
// Reset clears the sequencer to idle with all pins low, the read word to zero
// and the poll limit to 100.
module microwire_eeprom_master #(
  parameter int unsigned WORD_COUNT   = mwee_pkg::WORD_COUNT_DEF,
  parameter int unsigned ADDRESS_BITS = mwee_pkg::ADDRESS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mwee_pkg::mwee_req_t             in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mwee_pkg::mwee_res_t             out_res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mwee_pkg::POLL_W-1:0]     cfg_data_i
);
  import mwee_pkg::*;

  localparam logic [BITS_W-1:0] CMD_BITS   = BITS_W'(3 + ADDRESS_BITS);
  localparam logic [BITS_W-1:0] WRITE_BITS = BITS_W'(3 + ADDRESS_BITS + WORD_W);
  localparam logic [ADDR_W:0]   ADDR_LIMIT = (ADDR_W + 1)'(WORD_COUNT);

  // pipeline registers
  logic          in_valid_q;
  mwee_req_t     req_q;
  logic          out_valid_q;
  mwee_res_t     res_q;
  logic          advance;
  mwee_res_t     res_d;

  // sequencer state
  mwee_mode_e          mode_q, mode_d;
  logic                half_q, half_d;
  logic [BITS_W-1:0]   bits_q, bits_d;
  logic [SEND_W-1:0]   send_q, send_d;
  logic [WORD_W-1:0]   recv_q, recv_d;
  logic [POLL_W-1:0]   polls_q, polls_d;
  logic [OP_W-1:0]     cmd_q, cmd_d;
  logic [2:0]          pins_q, pins_d;
  mwee_status_e        pend_q, pend_d;
  logic [POLL_W-1:0]   poll_limit_q;

  // handshake
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;
  assign cfg_ready_o = 1'b1;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= POLL_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poll_limit_q <= cfg_data_i;
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      half_q  <= 1'b0;
      bits_q  <= '0;
      send_q  <= '0;
      recv_q  <= '0;
      polls_q <= '0;
      cmd_q   <= '0;
      pins_q  <= '0;
      pend_q  <= ST_OK;
    end else if (advance && in_valid_q) begin
      mode_q  <= mode_d;
      half_q  <= half_d;
      bits_q  <= bits_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
      polls_q <= polls_d;
      cmd_q   <= cmd_d;
      pins_q  <= pins_d;
      pend_q  <= pend_d;
    end
  end

  // next state and result for one tick
  always_comb begin
    logic                request;
    logic                reject;
    logic                done;
    logic                busy;
    mwee_status_e        status;
    logic [ADDRESS_BITS-1:0] addr_m;
    logic [BITS_W-1:0]   n;
    logic [BITS_W-1:0]   zmin;
    logic [2:0]          t;
    logic [POLL_W-1:0]   polls_nx;

    mode_d  = mode_q;
    half_d  = half_q;
    bits_d  = bits_q;
    send_d  = send_q;
    recv_d  = recv_q;
    polls_d = polls_q;
    cmd_d   = cmd_q;
    pins_d  = pins_q;
    pend_d  = pend_q;
    reject  = 1'b0;
    done    = 1'b0;
    busy    = 1'b0;
    status  = ST_OK;
    addr_m  = req_q.address[ADDRESS_BITS-1:0];
    n       = '0;
    zmin    = '0;
    t       = '0;
    polls_nx = '0;
    request = (req_q.operation == OP_READ) || (req_q.operation == OP_WRITE) ||
              (req_q.operation == OP_WEN) || (req_q.operation == OP_WDS);

    // command start or rejection
    if (mode_q == MODE_IDLE) begin
      if (request) begin
        if (((req_q.operation == OP_READ) || (req_q.operation == OP_WRITE)) &&
            ({1'b0, req_q.address} >= ADDR_LIMIT)) begin
          done   = 1'b1;
          status = ST_RANGE;
        end else begin
          cmd_d   = req_q.operation;
          pend_d  = ST_OK;
          polls_d = '0;
          half_d  = 1'b0;
          mode_d  = MODE_SEND;
          bits_d  = CMD_BITS;
          if (req_q.operation == OP_READ) begin
            send_d = SEND_W'({PAT_READ, addr_m});
          end else if (req_q.operation == OP_WRITE) begin
            send_d = SEND_W'({PAT_WRITE, addr_m, req_q.write_data});
            bits_d = WRITE_BITS;
          end else if (req_q.operation == OP_WEN) begin
            send_d = SEND_W'({PAT_WEN, {(ADDRESS_BITS-2){1'b0}}});
          end else begin
            send_d = SEND_W'({PAT_WDS, {(ADDRESS_BITS-2){1'b0}}});
          end
        end
      end
    end else if (request) begin
      reject = 1'b1;
    end

    // one half bit of the running command
    if (mode_d != MODE_IDLE) begin
      busy = 1'b1;
      unique case (mode_d)
        MODE_SEND: begin
          n      = (bits_d != '0) ? bits_d - 1'b1 : '0;
          pins_d = {send_d[n], half_d, 1'b1};
          if (!half_d) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            bits_d = n;
            if (n == '0) begin
              if (cmd_d == OP_READ) begin
                mode_d = MODE_RECV;
                bits_d = WORD_BITS;
              end else if (cmd_d == OP_WRITE) begin
                mode_d = MODE_ZERO_MID;
                bits_d = ZERO_TICKS;
              end else begin
                mode_d = MODE_ZERO_END;
                bits_d = ZERO_TICKS;
              end
            end
          end
        end
        MODE_RECV, MODE_POLL: begin
          pins_d = {pins_q[2], half_d, 1'b1};
          if (!half_d) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            bits_d = (bits_d != '0) ? bits_d - 1'b1 : '0;
            if (mode_d == MODE_RECV) begin
              recv_d = {recv_d[WORD_W-2:0], req_q.serial_in};
              if (bits_d == '0) begin
                mode_d = MODE_ZERO_END;
                bits_d = ZERO_TICKS;
              end
            end else if (bits_d == '0) begin
              if (req_q.serial_in) begin
                pend_d = ST_OK;
                mode_d = MODE_ZERO_END;
                bits_d = ZERO_TICKS;
              end else begin
                polls_nx = polls_d + 1'b1;
                polls_d  = polls_nx;
                if ((polls_nx >= poll_limit_q) || (polls_nx == '0)) begin
                  pend_d = ST_TIMEOUT;
                  mode_d = MODE_ZERO_END;
                  bits_d = ZERO_TICKS;
                end else begin
                  bits_d = POLL_BITS;
                end
              end
            end
          end
        end
        MODE_ZERO_MID, MODE_ZERO_END: begin
          // two zero clocks, then a clock-low tick that ends the phase (done only in MODE_ZERO_END)
          zmin   = (bits_d > ZERO_TICKS) ? ZERO_TICKS : bits_d;
          t      = 3'(ZERO_TICKS - zmin);
          pins_d = {1'b0, (t < 3'd4) ? t[0] : 1'b0, 1'b0};
          bits_d = (bits_d != '0) ? bits_d - 1'b1 : '0;
          if (bits_d == '0) begin
            if (mode_d == MODE_ZERO_MID) begin
              mode_d = MODE_POLL;
              bits_d = POLL_BITS;
              half_d = 1'b0;
            end else begin
              mode_d = MODE_IDLE;
              busy   = 1'b0;
              done   = 1'b1;
              status = pend_d;
              reject = 1'b0;
            end
          end
        end
        MODE_IDLE: begin
        end
        default: begin
        end
      endcase
    end

    if (reject) begin
      done   = 1'b1;
      status = ST_BUSY;
    end

    res_d.chip_select  = pins_d[0];
    res_d.serial_clock = pins_d[1];
    res_d.serial_out   = pins_d[2];
    res_d.busy_res     = busy;
    res_d.done_res     = done;
    res_d.read_data    = recv_d;
    res_d.status       = status;
  end

  // a busy done pulse is always a rejection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res && res_q.busy_res |-> res_q.status == ST_BUSY)
    else $error("done while busy without busy status");

  // status only reported with done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.done_res |-> res_q.status == ST_OK)
    else $error("status without done");

  // pins rest low when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> pins_q == 3'b000)
    else $error("pins active while idle");

  // sending always has bits left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SEND |-> bits_q != '0)
    else $error("send with no bits left");

endmodule
